// ===== hw/rtl/knot_span_index_search_defines.svh =====
// Assertion macros for the knot span index search block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef KNOT_SPAN_INDEX_SEARCH_DEFINES_SVH
`define KNOT_SPAN_INDEX_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active
`define KSIS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is active
`define KSIS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KSIS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define KSIS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/ksis_pkg.sv =====
// Shared constants and codes for the knot span index search block.
// No dependencies.
`default_nettype none

package ksis_pkg;

  // Field widths
  localparam int KNOT_W    = 32;
  localparam int ADDR_W    = 6;
  localparam int SPAN_W    = 6;
  localparam int ORDER_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int TOL_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Table depth default
  localparam int DEF_MAX_KNOTS = 64;

  // Register reset values
  localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(8);
  localparam logic [TOL_W-1:0]   TOL_RST   = TOL_W'(1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURVE_ORDER = 2'd0,
    CFG_KNOT_COUNT  = 2'd1,
    CFG_SNAP_TOL    = 2'd2
  } cfg_reg_t;

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/knot_span_index_search.sv =====
// Knot span index search: knot table, bound snapping and sequential span scan.
// Depends on ksis_pkg, ksis_ram and knot_span_index_search_defines.svh.
// Query: a full scan reads both bounds, then one knot per cycle; a bound hit or upper out of domain
// skips the scan, lower out of domain stops after the lower bound, a bad config goes straight to the
// result. Input reopens as the result register loads. Loads: one per cycle while idle. Reset sets register defaults.
`default_nettype none
`include "knot_span_index_search_defines.svh"

module knot_span_index_search #(
  parameter int MAX_KNOTS = ksis_pkg::DEF_MAX_KNOTS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Item channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_func,
  input  wire logic [ksis_pkg::ADDR_W-1:0]      in_knot_addr,
  input  wire logic signed [ksis_pkg::KNOT_W-1:0] in_sample_value,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ksis_pkg::SPAN_W-1:0]           out_span_index,
  output logic                                  out_out_of_domain,
  // Configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ksis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ksis_pkg::CFG_DAT_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int IW = ((AW > ksis_pkg::ADDR_W) ? AW : ksis_pkg::ADDR_W) + 3;
  localparam int KW = ksis_pkg::KNOT_W;

  localparam logic signed [IW-1:0] ZERO = IW'(0);
  localparam logic signed [IW-1:0] ONE  = IW'(1);
  localparam logic signed [IW-1:0] TWO  = IW'(2);
  localparam logic        [IW-1:0] MAXK = IW'(MAX_KNOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LO,
    S_HI,
    S_SCAN,
    S_DONE
  } state_t;

  // Configuration registers
  logic [ksis_pkg::ORDER_W-1:0] curve_order_r;
  logic [ksis_pkg::COUNT_W-1:0] knot_count_r;
  logic [ksis_pkg::TOL_W-1:0]   snap_tol_r;

  // Sequencer state and datapath registers
  state_t                state_r,   state_nxt;
  logic signed [KW-1:0]  x_r,       x_nxt;
  logic [AW-1:0]         k_r,       k_nxt;
  logic                  prev_lt_r, prev_lt_nxt;
  logic                  eq_lo_r,   eq_lo_nxt;
  logic [IW-1:0]         span_r,    span_nxt;
  logic                  ood_r,     ood_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ksis_pkg::SPAN_W-1:0] out_span_r, out_span_nxt;
  logic                  out_ood_r, out_ood_nxt;

  // Derived configuration
  logic [IW-1:0]         cnt_u;
  logic signed [IW-1:0]  cnt_s;
  logic signed [IW-1:0]  ord_s;
  logic signed [IW-1:0]  lo_idx;
  logic signed [IW-1:0]  hi_idx;
  logic signed [IW-1:0]  up_span;
  logic                  cfg_bad;

  // Handshake and RAM signals
  logic                  in_xfer;
  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [KW-1:0]         ram_rdata;
  logic [IW-1:0]         addr_ext;

  // Shared subtract / compare unit
  logic signed [KW-1:0]  op_a;
  logic signed [KW-1:0]  op_b;
  logic signed [KW:0]    diff;
  logic signed [KW:0]    tol_ext;
  logic                  diff_gt;
  logic                  diff_zero;
  logic                  diff_lt_tol;
  logic                  knot_last;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid         = out_valid_r;
  assign out_span_index    = out_span_r;
  assign out_out_of_domain = out_ood_r;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_order_r <= ksis_pkg::ORDER_RST;
      knot_count_r  <= ksis_pkg::COUNT_RST;
      snap_tol_r    <= ksis_pkg::TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ksis_pkg::CFG_CURVE_ORDER: curve_order_r <= cfg_data[ksis_pkg::ORDER_W-1:0];
        ksis_pkg::CFG_KNOT_COUNT:  knot_count_r  <= cfg_data[ksis_pkg::COUNT_W-1:0];
        ksis_pkg::CFG_SNAP_TOL:    snap_tol_r    <= cfg_data[ksis_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp count to table depth and derive bound positions
  always_comb begin
    cnt_u   = (IW'(knot_count_r) > MAXK) ? MAXK : IW'(knot_count_r);
    cnt_s   = $signed(cnt_u);
    ord_s   = $signed(IW'(curve_order_r));
    lo_idx  = ord_s - ONE;
    hi_idx  = cnt_s - ord_s + ONE;
    up_span = cnt_s - ord_s - ONE;
    cfg_bad = (cnt_s < TWO) || (ord_s < ONE) || (lo_idx > cnt_s - ONE) ||
              (hi_idx < ZERO) || (hi_idx > cnt_s - ONE) || (lo_idx > hi_idx) ||
              (up_span < ZERO);
  end

  // Knot table write on load transfers inside the table
  assign addr_ext = IW'(in_knot_addr);
  assign ram_we   = in_xfer && (in_func == ksis_pkg::FUNC_LOAD) && (addr_ext < MAXK);

  // Read address follows the sequencer
  always_comb begin
    case (state_r)
      S_IDLE:  ram_raddr = lo_idx[AW-1:0];
      S_LO:    ram_raddr = hi_idx[AW-1:0];
      S_HI:    ram_raddr = '0;
      S_SCAN:  ram_raddr = k_r + AW'(1);
      default: ram_raddr = '0;
    endcase
  end

  ksis_ram #(
    .WIDTH (KW),
    .DEPTH (MAX_KNOTS)
  ) u_knot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_ext[AW-1:0]),
    .wdata (in_sample_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared subtractor: lower bound minus value, else value minus knot
  always_comb begin
    if (state_r == S_LO) begin
      op_a = $signed(ram_rdata);
      op_b = x_r;
    end else begin
      op_a = x_r;
      op_b = $signed(ram_rdata);
    end
    diff        = {op_a[KW-1], op_a} - {op_b[KW-1], op_b};
    tol_ext     = $signed({{(KW + 1 - ksis_pkg::TOL_W){1'b0}}, snap_tol_r});
    diff_zero   = (diff == '0);
    diff_gt     = !diff[KW] && !diff_zero;
    diff_lt_tol = (diff < tol_ext);
    knot_last   = (IW'(k_r) == cnt_u - IW'(1));
  end

  // Sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    k_nxt         = k_r;
    prev_lt_nxt   = prev_lt_r;
    eq_lo_nxt     = eq_lo_r;
    span_nxt      = span_r;
    ood_nxt       = ood_r;
    out_valid_nxt = out_valid_r;
    out_span_nxt  = out_span_r;
    out_ood_nxt   = out_ood_r;

    // Drop the result once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_func == ksis_pkg::FUNC_QUERY)) begin
          x_nxt    = in_sample_value;
          span_nxt = '0;
          ood_nxt  = cfg_bad;
          state_nxt = cfg_bad ? S_DONE : S_LO;
        end
      end
      // Lower bound arrives: flag or snap a value below it
      S_LO: begin
        if (diff_gt && !diff_lt_tol) begin
          ood_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          if (diff_gt) begin
            x_nxt = $signed(ram_rdata);
          end
          eq_lo_nxt = 1'b1;
          if (!diff_gt && !diff_zero) begin
            eq_lo_nxt = 1'b0;
          end
          state_nxt = S_HI;
        end
      end
      // Upper bound arrives: flag, snap, resolve a bound hit, or start the scan
      S_HI: begin
        if (diff_gt && !diff_lt_tol) begin
          ood_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (diff_gt || diff_zero) begin
          span_nxt  = up_span;
          state_nxt = S_DONE;
        end else if (eq_lo_r) begin
          span_nxt  = lo_idx;
          state_nxt = S_DONE;
        end else begin
          k_nxt       = '0;
          prev_lt_nxt = 1'b0;
          state_nxt   = S_SCAN;
        end
      end
      // One knot per cycle: keep the last k-1 with knot[k-1] < x <= knot[k]
      S_SCAN: begin
        if ((k_r != '0) && prev_lt_r && !diff_gt) begin
          span_nxt = IW'(k_r) - IW'(1);
        end
        prev_lt_nxt = diff_gt;
        k_nxt       = k_r + AW'(1);
        if (knot_last) begin
          state_nxt = S_DONE;
        end
      end
      // Hand the result to the output register when it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_span_nxt  = span_r[ksis_pkg::SPAN_W-1:0];
          out_ood_nxt   = ood_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    k_r        <= k_nxt;
    prev_lt_r  <= prev_lt_nxt;
    eq_lo_r    <= eq_lo_nxt;
    span_r     <= span_nxt;
    ood_r      <= ood_nxt;
    out_span_r <= out_span_nxt;
    out_ood_r  <= out_ood_nxt;
  end

  // Checks
  `KSIS_ASSERT_IMP(a_ood_span_zero, clk, rst_n, out_valid && out_out_of_domain,
    out_span_index == '0, "out-of-domain result carries a nonzero span")
  `KSIS_ASSERT_IMP(a_scan_in_range, clk, rst_n, state_r == S_SCAN,
    IW'(k_r) < cnt_u, "scan index ran past the knot count")
  `KSIS_ASSERT_NXT(a_query_starts, clk, rst_n, in_xfer && (in_func == ksis_pkg::FUNC_QUERY),
    (state_r == S_LO) || (state_r == S_DONE), "query did not start the sequencer")
  `KSIS_ASSERT_NXT(a_load_stays_ready, clk, rst_n, in_xfer && (in_func == ksis_pkg::FUNC_LOAD),
    !in_stall, "load left the block busy")

endmodule

`default_nettype wire

// ===== hw/rtl/ksis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ksis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
